[design/rtp_pkg.sv]
// shared codes and types for the rule transmission parser
package rtp_pkg;

  // marker bytes
  localparam logic [7:0] MarkStart  = 8'h81;
  localparam logic [7:0] MarkEnd    = 8'h82;
  localparam logic [7:0] MarkBlkBeg = 8'h83;
  localparam logic [7:0] MarkBlkEnd = 8'h84;
  localparam logic [7:0] MarkSep    = 8'h85;

  localparam int unsigned ValueW = 21;

  typedef enum logic [2:0] {
    KIND_HEAD   = 3'd0,
    KIND_TERM   = 3'd1,
    KIND_NONT   = 3'd2,
    KIND_SEP    = 3'd3,
    KIND_BEND   = 3'd4,
    KIND_BSTART = 3'd5,
    KIND_DONE   = 3'd6
  } sym_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_START    = 4'd1,
    ERR_BAD_HEAD    = 4'd2,
    ERR_BAD_CONT    = 4'd3,
    ERR_SHORT_BODY  = 4'd4,
    ERR_BAD_MARKER  = 4'd5,
    ERR_BAD_BODY    = 4'd6,
    ERR_BAD_BETWEEN = 4'd7,
    ERR_TRAILING    = 4'd8,
    ERR_EARLY_END   = 4'd9
  } err_code_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    sym_kind_e         kind;
    err_code_e         err;
  } result_t;

endpackage

[design/rule_transmission_parser.sv]
// rule transmission parser: byte-wise grammar check and utf-8 symbol decode
//
// input channel (s_axis): one byte per transfer in tdata; tlast high marks
// the end of the stream, and then tdata is ignored.
// output channel (m_axis): one result per decoded symbol, per block or
// separator marker, and one final done result carrying the error code
// (zero when the transmission was well formed).
// the parse state updates in the cycle of the input transfer; the result is
// registered at that transfer, into the output register or else the skid.
// throughput is one byte per cycle while tready is high, set by the single
// decode step between the input handshake and the output register.
// a one-entry skid register behind the output register keeps the input
// side taking bytes while a result waits; tready drops only when both are
// full, and rises again once the receiver takes a result.
// after the done result, or the first error, all further input is taken
// and dropped until reset.
// reset puts the parser back to expecting the start marker and empties
// both output registers.
module rule_transmission_parser
  import rtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] sym_value, [23:21] zero
  output logic [6:0]  m_axis_tuser    // [2:0] sym_kind, [6:3] error_code
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_BETWEEN = 3'd1;
  localparam logic [2:0] PH_HEAD    = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_CONT    = 3'd4;
  localparam logic [2:0] PH_TAIL    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  logic [2:0]        phase_q, phase_d;
  logic [ValueW-1:0] accum_q, accum_d;
  logic [1:0]        remain_q, remain_d;
  sym_kind_e         pend_q, pend_d;
  logic [1:0]        body_q, body_d;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    in_fire, out_fire, push;
  result_t res;
  logic    res_valid;
  logic [7:0] b;
  logic [1:0] body_inc;
  logic [ValueW-1:0] accum_shift;

  assign s_axis_tready = ~skid_valid_q;
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = out_valid_q & m_axis_tready;
  assign b        = s_axis_tdata;
  assign body_inc = (body_q == 2'd2) ? body_q : body_q + 2'd1;
  assign accum_shift = {accum_q[ValueW-7:0], b[5:0]};

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    remain_d  = remain_q;
    pend_d    = pend_q;
    body_d    = body_q;
    res_valid = 1'b0;
    res       = '{value: '0, kind: KIND_DONE, err: ERR_NONE};

    if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
      // stream is finished: drop everything
    end else if (s_axis_tlast) begin
      res_valid = 1'b1;
      if (phase_q == PH_TAIL) begin
        phase_d = PH_DONE;
      end else begin
        phase_d = PH_ERROR;
        res.err = ERR_EARLY_END;
      end
    end else begin
      case (phase_q)
        PH_START: begin
          if (b == MarkStart) begin
            phase_d = PH_BETWEEN;
          end else begin
            res_valid = 1'b1;
            res.err   = ERR_NO_START;
            phase_d   = PH_ERROR;
          end
        end
        PH_BETWEEN: begin
          if (b == MarkBlkBeg) begin
            phase_d   = PH_HEAD;
            res_valid = 1'b1;
            res.kind  = KIND_BSTART;
          end else if (b == MarkEnd) begin
            phase_d = PH_TAIL;
          end else begin
            res_valid = 1'b1;
            res.err   = ERR_BAD_BETWEEN;
            phase_d   = PH_ERROR;
          end
        end
        PH_HEAD, PH_BODY: begin
          // nonterminal lead bytes are legal in both phases
          if (b inside {[8'hC4:8'hDF]}) begin
            accum_d  = ValueW'(b[4:0]);
            remain_d = 2'd1;
            pend_d   = (phase_q == PH_HEAD) ? KIND_HEAD : KIND_NONT;
            phase_d  = PH_CONT;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            accum_d  = ValueW'(b[3:0]);
            remain_d = 2'd2;
            pend_d   = (phase_q == PH_HEAD) ? KIND_HEAD : KIND_NONT;
            phase_d  = PH_CONT;
          end else if (b inside {[8'hF0:8'hF7]}) begin
            accum_d  = ValueW'(b[2:0]);
            remain_d = 2'd3;
            pend_d   = (phase_q == PH_HEAD) ? KIND_HEAD : KIND_NONT;
            phase_d  = PH_CONT;
          end else if (phase_q == PH_HEAD) begin
            res_valid = 1'b1;
            res.err   = ERR_BAD_HEAD;
            phase_d   = PH_ERROR;
          end else if (b[7:6] == 2'b10) begin
            res_valid = 1'b1;
            if (body_q != 2'd2) begin
              res.err = ERR_SHORT_BODY;
              phase_d = PH_ERROR;
            end else if (b == MarkSep) begin
              res.kind = KIND_SEP;
              phase_d  = PH_HEAD;
            end else if (b == MarkBlkEnd) begin
              res.kind = KIND_BEND;
              phase_d  = PH_BETWEEN;
            end else begin
              res.err = ERR_BAD_MARKER;
              phase_d = PH_ERROR;
            end
          end else if (b[7] == 1'b0) begin
            res_valid = 1'b1;
            res.value = ValueW'(b);
            res.kind  = KIND_TERM;
            body_d    = body_inc;
          end else if (b[7:2] == 6'b110000) begin
            // two-byte terminal, lead c0..c3
            accum_d  = ValueW'(b[4:0]);
            remain_d = 2'd1;
            pend_d   = KIND_TERM;
            phase_d  = PH_CONT;
          end else begin
            res_valid = 1'b1;
            res.err   = ERR_BAD_BODY;
            phase_d   = PH_ERROR;
          end
        end
        PH_CONT: begin
          if (b[7:6] != 2'b10) begin
            res_valid = 1'b1;
            res.err   = ERR_BAD_CONT;
            phase_d   = PH_ERROR;
          end else begin
            accum_d  = accum_shift;
            remain_d = remain_q - 2'd1;
            if (remain_q == 2'd1) begin
              phase_d   = PH_BODY;
              body_d    = (pend_q == KIND_HEAD) ? 2'd0 : body_inc;
              res_valid = 1'b1;
              res.value = accum_shift;
              res.kind  = pend_q;
            end
          end
        end
        PH_TAIL: begin
          res_valid = 1'b1;
          res.err   = ERR_TRAILING;
          phase_d   = PH_ERROR;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  assign push = in_fire & res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      accum_q  <= '0;
      remain_q <= '0;
      pend_q   <= KIND_HEAD;
      body_q   <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      remain_q <= remain_d;
      pend_q   <= pend_d;
      body_q   <= body_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.value};
  assign m_axis_tuser  = {out_q.err, out_q.kind};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_cont_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CONT) |-> (remain_q != 2'd0))
    else $error("continuation phase with no bytes left");

  a_done_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res.kind == KIND_DONE) |=> (phase_q == PH_DONE || phase_q == PH_ERROR))
    else $error("done result without final phase");

  a_err_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.err != ERR_NONE) |-> (out_q.kind == KIND_DONE))
    else $error("error code on a non-done result");

  a_no_result_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE || phase_q == PH_ERROR) |-> !push)
    else $error("result produced after end of stream");
`endif

endmodule

[dv/rule_transmission_parser_tb.sv]
// testbench for the rule transmission parser: directed and random byte streams checked per result
module rule_transmission_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtp_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldAt      = 150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StreamBytes = 1320;

  typedef enum logic [2:0] {
    WAIT_START, BETWEEN_BLOCKS, WANT_HEAD, IN_BODY, IN_SEQUENCE, AFTER_END, FINISHED, FAILED
  } parse_phase_e;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } stream_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [6:0]  m_axis_tuser;

  rule_transmission_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  stream_item_t pending_bytes[$];
  result_t      expected_symbols[$];
  err_code_e    ending;
  int unsigned  symbols_seen = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  logic [31:0]  cycle_cnt = '0;

  // parser model state
  parse_phase_e phase_q;
  logic [20:0]  accum_q;
  logic [1:0]   remain_q;
  sym_kind_e    pend_kind_q;
  logic [1:0]   body_cnt_q;
  err_code_e    err_q;

  function automatic bit raise_error(input err_code_e code, output result_t res);
    err_q   = code;
    phase_q = FAILED;
    res     = '{value: '0, kind: KIND_DONE, err: code};
    return 1'b1;
  endfunction

  // opens a 2..4 byte nonterminal on a C4..F7 lead
  function automatic bit open_multibyte(input logic [7:0] b, input sym_kind_e kind);
    if (b >= 8'hC4 && b[7:5] == 3'b110) begin
      accum_q  = 21'(b[4:0]);
      remain_q = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      accum_q  = 21'(b[3:0]);
      remain_q = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      accum_q  = 21'(b[2:0]);
      remain_q = 2'd3;
    end else begin
      return 1'b0;
    end
    pend_kind_q = kind;
    phase_q     = IN_SEQUENCE;
    return 1'b1;
  endfunction

  // advances the parser model by one transfer; returns 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic eoi, output result_t res);
    res = '{value: '0, kind: KIND_DONE, err: ERR_NONE};
    if (phase_q == FINISHED || phase_q == FAILED || err_q != ERR_NONE) return 1'b0;
    if (eoi) begin
      if (phase_q == AFTER_END) begin
        phase_q = FINISHED;
        return 1'b1;
      end
      return raise_error(ERR_EARLY_END, res);
    end
    case (phase_q)
      WAIT_START: begin
        if (b != MarkStart) return raise_error(ERR_NO_START, res);
        phase_q = BETWEEN_BLOCKS;
      end
      BETWEEN_BLOCKS: begin
        if (b == MarkBlkBeg) begin
          phase_q  = WANT_HEAD;
          res.kind = KIND_BSTART;
          return 1'b1;
        end
        if (b == MarkEnd) begin
          phase_q = AFTER_END;
          return 1'b0;
        end
        return raise_error(ERR_BAD_BETWEEN, res);
      end
      WANT_HEAD: begin
        if (!open_multibyte(b, KIND_HEAD)) return raise_error(ERR_BAD_HEAD, res);
      end
      IN_BODY: begin
        if (b[7:6] == 2'b10) begin
          // any marker before two body symbols is a short body
          if (body_cnt_q < 2'd2) return raise_error(ERR_SHORT_BODY, res);
          if (b == MarkSep) begin
            phase_q  = WANT_HEAD;
            res.kind = KIND_SEP;
            return 1'b1;
          end
          if (b == MarkBlkEnd) begin
            phase_q  = BETWEEN_BLOCKS;
            res.kind = KIND_BEND;
            return 1'b1;
          end
          return raise_error(ERR_BAD_MARKER, res);
        end
        if (!b[7]) begin
          if (body_cnt_q != 2'd2) body_cnt_q++;
          res.value = 21'(b);
          res.kind  = KIND_TERM;
          return 1'b1;
        end
        if (b[7:2] == 6'b110000) begin
          accum_q     = 21'(b[4:0]);
          remain_q    = 2'd1;
          pend_kind_q = KIND_TERM;
          phase_q     = IN_SEQUENCE;
          return 1'b0;
        end
        if (!open_multibyte(b, KIND_NONT)) return raise_error(ERR_BAD_BODY, res);
      end
      IN_SEQUENCE: begin
        if (b[7:6] != 2'b10) return raise_error(ERR_BAD_CONT, res);
        accum_q  = {accum_q[14:0], b[5:0]};
        remain_q = remain_q - 2'd1;
        if (remain_q != 2'd0) return 1'b0;
        phase_q = IN_BODY;
        if (pend_kind_q == KIND_HEAD) body_cnt_q = 2'd0;
        else if (body_cnt_q != 2'd2) body_cnt_q++;
        res.value = accum_q;
        res.kind  = pend_kind_q;
        return 1'b1;
      end
      AFTER_END: return raise_error(ERR_TRAILING, res);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // stream building

  function automatic void put(input logic [7:0] b);
    pending_bytes.push_back('{last: 1'b0, data: b});
  endfunction

  function automatic void put_eoi();
    pending_bytes.push_back('{last: 1'b1, data: 8'($urandom)});
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic void put_nonterminal();
    int unsigned n;
    n = $urandom_range(1, 3);
    case (n)
      1: put(8'($urandom_range(32'hC4, 32'hDF)));
      2: put(8'($urandom_range(32'hE0, 32'hEF)));
      default: put(8'($urandom_range(32'hF0, 32'hF7)));
    endcase
    repeat (n) put(cont_byte());
  endfunction

  function automatic void put_body_symbol();
    case ($urandom_range(0, 3))
      0, 1: put(8'($urandom_range(0, 127)));
      2: begin
        put(8'($urandom_range(32'hC0, 32'hC3)));
        put(cont_byte());
      end
      default: put_nonterminal();
    endcase
  endfunction

  function automatic void put_rule(input int unsigned body_len);
    put_nonterminal();
    repeat (body_len) put_body_symbol();
  endfunction

  function automatic void put_block();
    int unsigned rules;
    rules = $urandom_range(1, 4);
    put(MarkBlkBeg);
    for (int i = 0; i < rules; i++) begin
      if (i != 0) put(MarkSep);
      put_rule($urandom_range(2, 6));
    end
    put(MarkBlkEnd);
  endfunction

  function automatic int unsigned draw_gap(input logic calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // idle-free stretches in turn, set by counter bits 10 and 9: both sides, sender only, receiver only, neither
  wire tx_calm = !cycle_cnt[10];
  wire rx_calm = !cycle_cnt[9];

  // sender
  stream_item_t tx_item;
  int unsigned  tx_wait;
  int unsigned  tx_next_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_wait       <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      tx_next_wait = s_axis_tvalid ? draw_gap(tx_calm) : tx_wait;
      if (tx_next_wait == 0 && pending_bytes.size() != 0) begin
        tx_item = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tx_item.data;
        s_axis_tlast  <= tx_item.last;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (tx_next_wait != 0) tx_wait <= tx_next_wait - 1;
      end
    end
  end

  // receiver, with one long hold-off so the parser backs up into its input
  int unsigned rx_wait;
  int unsigned rx_next_wait;
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && symbols_seen >= HoldAt) begin
      hold_done     <= 1'b1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end else if (m_axis_tvalid) begin
      rx_next_wait = draw_gap(rx_calm);
      m_axis_tready <= (rx_next_wait == 0);
      rx_wait       <= rx_next_wait;
    end
  end

  // result checking first, then prediction for the byte taken at this edge
  result_t awaited;
  result_t predicted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     = WAIT_START;
      accum_q     = '0;
      remain_q    = '0;
      pend_kind_q = KIND_HEAD;
      body_cnt_q  = '0;
      err_q       = ERR_NONE;
      expected_symbols.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        symbols_seen <= symbols_seen + 1;
        if (expected_symbols.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected: data 0x%0h user 0x%0h",
                                  symbols_seen, m_axis_tdata, m_axis_tuser));
        end else begin
          awaited = expected_symbols.pop_front();
          if (m_axis_tdata != {3'b000, awaited.value})
            note_mismatch($sformatf("result %0d: value expected 0x%0h, got 0x%0h",
                                    symbols_seen, awaited.value, m_axis_tdata));
          if (m_axis_tuser[2:0] != awaited.kind)
            note_mismatch($sformatf("result %0d: kind expected %0d, got %0d",
                                    symbols_seen, awaited.kind, m_axis_tuser[2:0]));
          if (m_axis_tuser[6:3] != awaited.err)
            note_mismatch($sformatf("result %0d: error expected %0d, got %0d",
                                    symbols_seen, awaited.err, m_axis_tuser[6:3]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken <= bytes_taken + 1;
        if (decode_byte(s_axis_tdata, s_axis_tlast, predicted))
          expected_symbols.push_back(predicted);
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               StallLimit, expected_symbols.size());
      $display("rule_transmission_parser regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // a valid block touching the value extremes and overlong forms
    logic [7:0]  opening [21] = '{
      8'h83, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h7F, 8'hC3, 8'hBF, 8'hC0, 8'h80,
      8'h85, 8'hC4, 8'h80, 8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'h84};
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;

    pick   = $urandom_range(0, 13);
    ending = (pick < 5) ? ERR_NONE : err_code_e'(pick - 4);

    if (ending == ERR_NO_START) begin
      do b = 8'($urandom); while (b == MarkStart);
      put(b);
    end else begin
      put(MarkStart);
    end
    foreach (opening[i]) put(opening[i]);
    while (pending_bytes.size() < StreamBytes) put_block();

    case (ending)
      ERR_BAD_HEAD: begin
        put(MarkBlkBeg);
        if ($urandom_range(0, 1)) begin
          put_rule($urandom_range(2, 4));
          put(MarkSep);
        end
        // an immediate block end makes an empty block
        if ($urandom_range(0, 3) == 0) b = MarkBlkEnd;
        else do b = 8'($urandom); while (b >= 8'hC4 && b <= 8'hF7);
        put(b);
      end
      ERR_BAD_CONT: begin
        put(MarkBlkBeg);
        if ($urandom_range(0, 1)) begin
          put_nonterminal();
          put_body_symbol();
          b = 8'($urandom_range(32'hC0, 32'hF7));
        end else begin
          b = 8'($urandom_range(32'hC4, 32'hF7));
        end
        put(b);
        n = (b < 8'hE0) ? 1 : (b < 8'hF0) ? 2 : 3;
        repeat ($urandom_range(0, n - 1)) put(cont_byte());
        do b = 8'($urandom); while (b[7:6] == 2'b10);
        put(b);
      end
      ERR_SHORT_BODY: begin
        put(MarkBlkBeg);
        put_nonterminal();
        repeat ($urandom_range(0, 1)) put_body_symbol();
        case ($urandom_range(0, 2))
          0: put(MarkSep);
          1: put(MarkBlkEnd);
          default: put(8'($urandom_range(32'h80, 32'hBF)));
        endcase
      end
      ERR_BAD_MARKER: begin
        put(MarkBlkBeg);
        put_rule($urandom_range(2, 4));
        do b = 8'($urandom_range(32'h80, 32'hBF)); while (b == MarkSep || b == MarkBlkEnd);
        put(b);
      end
      ERR_BAD_BODY: begin
        put(MarkBlkBeg);
        put_rule($urandom_range(0, 3));
        put(8'($urandom_range(32'hF8, 32'hFF)));
      end
      ERR_BAD_BETWEEN: begin
        do b = 8'($urandom); while (b == MarkEnd || b == MarkBlkBeg);
        put(b);
      end
      ERR_TRAILING: begin
        put(MarkEnd);
        put(8'($urandom));
      end
      ERR_EARLY_END: begin
        // cut the stream between blocks, before a head, in a body or inside a sequence
        k = $urandom_range(0, 3);
        if (k >= 1) put(MarkBlkBeg);
        if (k >= 2) put_nonterminal();
        if (k == 3) put(8'($urandom_range(32'hC0, 32'hF7)));
        put_eoi();
      end
      default: begin
        put(MarkEnd);
        put_eoi();
      end
    endcase

    // everything after the verdict is taken and dropped
    repeat (20) begin
      if ($urandom_range(0, 3) == 0) put_eoi();
      else put(8'($urandom));
    end
    put_eoi();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("streamed %0d bytes, checked %0d results, %0d mismatches",
             bytes_taken, symbols_seen, mismatch_count);
    $display("transmission closed by %s, output held off %0d cycles once",
             ending.name(), HoldCycles);
    if (mismatch_count == 0) begin
      $display("rule_transmission_parser regression: pass");
    end else begin
      $display("rule_transmission_parser regression: fail");
    end
    $finish;
  end

endmodule
